// ----- rtl/irq_nmi_latch_mask_controller_defines.svh -----
// Assertion macros used by the checker file of the interrupt controller.
`ifndef IRQ_NMI_LATCH_MASK_CONTROLLER_DEFINES_SVH
`define IRQ_NMI_LATCH_MASK_CONTROLLER_DEFINES_SVH

// Check a property on aclk, skipped while reset is held.
`define INLMC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on aclk, also while reset is held.
`define INLMC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- rtl/inlmc_pkg.sv -----
package inlmc_pkg;

    // Event codes carried in the opcode field
    typedef enum logic [3:0] {
        OP_TIMER       = 4'd0,
        OP_DISK        = 4'd1,
        OP_MOTOROFF    = 4'd2,
        OP_UART_ERR    = 4'd3,
        OP_UART_RCV    = 4'd4,
        OP_UART_SND    = 4'd5,
        OP_RESET_BTN   = 4'd6,
        OP_CASS_RISE   = 4'd7,
        OP_CASS_FALL   = 4'd8,
        OP_CASS_CLEAR  = 4'd9,
        OP_IRQ_READ    = 4'd10,
        OP_IRQ_MASK_WR = 4'd11,
        OP_NMI_READ    = 4'd12,
        OP_NMI_MASK_WR = 4'd13
    } op_t;

    // Machine mode register values
    localparam logic MODE_EARLY = 1'b0;
    localparam logic MODE_LATE  = 1'b1;

    // IRQ latch bits
    localparam logic [7:0] EARLY_TIMER   = 8'h80;
    localparam logic [7:0] EARLY_DISK    = 8'h40;
    localparam logic [7:0] LATE_UART_ERR = 8'h40;
    localparam logic [7:0] LATE_UART_RCV = 8'h20;
    localparam logic [7:0] LATE_UART_SND = 8'h10;
    localparam logic [7:0] LATE_TIMER    = 8'h04;
    localparam logic [7:0] CASS_FALL     = 8'h02;
    localparam logic [7:0] CASS_RISE     = 8'h01;

    // NMI latch bits
    localparam logic [7:0] NMI_INTRQ    = 8'h80;
    localparam logic [7:0] NMI_MOTOROFF = 8'h40;
    localparam logic [7:0] NMI_RESET    = 8'h20;

    // Reset values of latches and masks
    localparam logic [7:0] IRQ_LATCH_RST = 8'h00;
    localparam logic [7:0] IRQ_MASK_RST  = 8'h00;
    localparam logic [7:0] NMI_LATCH_RST = 8'h01;
    localparam logic [7:0] NMI_MASK_RST  = NMI_RESET;

    // Input beat
    typedef struct packed {
        logic [3:0] opcode;
        logic       line_level;
        logic [7:0] write_data;
    } in_item_t;

    // Result beat
    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_line;
        logic       nmi_line;
        logic       nmi_seen_clear;
        logic [1:0] cassette_enabled;
    } out_item_t;

    // Handoff control between the input register and the result register
    typedef struct packed {
        logic item_valid;
        logic advance;
    } pipe_ctl_t;

endpackage

// ----- rtl/inlmc_in_stage.sv -----
module inlmc_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  inlmc_pkg::in_item_t s_data,
    input  logic                advance,
    output logic                item_valid,
    output inlmc_pkg::in_item_t item
);

    logic                valid_reg;
    logic                valid_next;
    inlmc_pkg::in_item_t item_reg;

    // Take a beat when empty or when the held item moves on this cycle
    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Hold the payload until it moves on
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- rtl/inlmc_core.sv -----
module inlmc_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic                 cfg_data,
    input  inlmc_pkg::pipe_ctl_t ctl,
    input  inlmc_pkg::in_item_t  item,
    output inlmc_pkg::out_item_t result
);

    logic       mode_reg;
    logic [7:0] irq_latch_reg;
    logic [7:0] irq_latch_next;
    logic [7:0] irq_mask_reg;
    logic [7:0] irq_mask_next;
    logic [7:0] nmi_latch_reg;
    logic [7:0] nmi_latch_next;
    logic [7:0] nmi_mask_reg;
    logic [7:0] nmi_mask_next;
    logic       irq_out_reg;
    logic       irq_out_next;
    logic       nmi_out_reg;
    logic       nmi_out_next;
    logic [7:0] rd;
    logic       nmi_touched;
    logic       late;

    function automatic logic [7:0] put_bit(input logic [7:0] v, input logic [7:0] b,
                                           input logic on);
        return on ? (v | b) : (v & ~b);
    endfunction

    assign late = (mode_reg != inlmc_pkg::MODE_EARLY);

    // Apply one event to the latches, masks and lines
    always_comb begin
        irq_latch_next = irq_latch_reg;
        irq_mask_next  = irq_mask_reg;
        nmi_latch_next = nmi_latch_reg;
        nmi_mask_next  = nmi_mask_reg;
        irq_out_next   = irq_out_reg;
        nmi_out_next   = nmi_out_reg;
        rd             = 8'h00;
        nmi_touched    = 1'b0;
        unique case (item.opcode)
            inlmc_pkg::OP_TIMER: begin
                if (!late) begin
                    irq_latch_next = put_bit(irq_latch_reg, inlmc_pkg::EARLY_TIMER,
                                             item.line_level);
                    if (item.line_level) begin
                        irq_out_next = 1'b1;
                    end
                end else begin
                    irq_latch_next = put_bit(irq_latch_reg, inlmc_pkg::LATE_TIMER,
                                             item.line_level);
                    irq_out_next   = |(irq_latch_next & irq_mask_reg);
                end
            end
            inlmc_pkg::OP_DISK: begin
                if (!late) begin
                    irq_latch_next = put_bit(irq_latch_reg, inlmc_pkg::EARLY_DISK,
                                             item.line_level);
                    if (item.line_level) begin
                        irq_out_next = 1'b1;
                    end
                end else begin
                    nmi_latch_next = put_bit(nmi_latch_reg, inlmc_pkg::NMI_INTRQ,
                                             item.line_level);
                    nmi_out_next   = |(nmi_latch_next & nmi_mask_reg);
                    nmi_touched    = 1'b1;
                end
            end
            inlmc_pkg::OP_MOTOROFF: begin
                if (late) begin
                    nmi_latch_next = put_bit(nmi_latch_reg, inlmc_pkg::NMI_MOTOROFF,
                                             item.line_level);
                    nmi_out_next   = |(nmi_latch_next & nmi_mask_reg);
                    nmi_touched    = 1'b1;
                end
            end
            inlmc_pkg::OP_UART_ERR: begin
                if (late) begin
                    irq_latch_next = put_bit(irq_latch_reg, inlmc_pkg::LATE_UART_ERR,
                                             item.line_level);
                    irq_out_next   = |(irq_latch_next & irq_mask_reg);
                end
            end
            inlmc_pkg::OP_UART_RCV: begin
                if (late) begin
                    irq_latch_next = put_bit(irq_latch_reg, inlmc_pkg::LATE_UART_RCV,
                                             item.line_level);
                    irq_out_next   = |(irq_latch_next & irq_mask_reg);
                end
            end
            inlmc_pkg::OP_UART_SND: begin
                if (late) begin
                    irq_latch_next = put_bit(irq_latch_reg, inlmc_pkg::LATE_UART_SND,
                                             item.line_level);
                    irq_out_next   = |(irq_latch_next & irq_mask_reg);
                end
            end
            inlmc_pkg::OP_RESET_BTN: begin
                // Early machines wire the button straight to the NMI line
                if (!late) begin
                    nmi_out_next = item.line_level;
                end else begin
                    nmi_latch_next = put_bit(nmi_latch_reg, inlmc_pkg::NMI_RESET,
                                             item.line_level);
                    nmi_out_next   = |(nmi_latch_next & nmi_mask_reg);
                end
                nmi_touched = 1'b1;
            end
            inlmc_pkg::OP_CASS_RISE: begin
                irq_latch_next = (irq_latch_reg & ~inlmc_pkg::CASS_RISE)
                               | (irq_mask_reg & inlmc_pkg::CASS_RISE);
                irq_out_next   = |(irq_latch_next & irq_mask_reg);
            end
            inlmc_pkg::OP_CASS_FALL: begin
                irq_latch_next = (irq_latch_reg & ~inlmc_pkg::CASS_FALL)
                               | (irq_mask_reg & inlmc_pkg::CASS_FALL);
                irq_out_next   = |(irq_latch_next & irq_mask_reg);
            end
            inlmc_pkg::OP_CASS_CLEAR: begin
                irq_latch_next = irq_latch_reg
                               & ~(inlmc_pkg::CASS_RISE | inlmc_pkg::CASS_FALL);
                irq_out_next   = |(irq_latch_next & irq_mask_reg);
            end
            inlmc_pkg::OP_IRQ_READ: begin
                // Early read acknowledges the timer bit only
                if (!late) begin
                    rd             = irq_latch_reg;
                    irq_latch_next = irq_latch_reg & ~inlmc_pkg::EARLY_TIMER;
                    irq_out_next   = |irq_latch_next;
                end else begin
                    rd = ~irq_latch_reg;
                end
            end
            inlmc_pkg::OP_IRQ_MASK_WR: begin
                irq_mask_next = item.write_data;
                irq_out_next  = |(irq_latch_reg & irq_mask_next);
            end
            inlmc_pkg::OP_NMI_READ: begin
                rd = ~nmi_latch_reg;
            end
            inlmc_pkg::OP_NMI_MASK_WR: begin
                // Keep the reset button unmasked
                nmi_mask_next = item.write_data | inlmc_pkg::NMI_RESET;
                nmi_out_next  = |(nmi_latch_reg & nmi_mask_next);
                nmi_touched   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Build the result beat
    always_comb begin
        result.read_data        = rd;
        result.irq_line         = irq_out_next;
        result.nmi_line         = nmi_out_next;
        result.nmi_seen_clear   = nmi_touched && !nmi_out_next;
        result.cassette_enabled = irq_mask_next[1:0];
    end

    // Commit state when the item moves into the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            irq_latch_reg <= inlmc_pkg::IRQ_LATCH_RST;
            irq_mask_reg  <= inlmc_pkg::IRQ_MASK_RST;
            nmi_latch_reg <= inlmc_pkg::NMI_LATCH_RST;
            nmi_mask_reg  <= inlmc_pkg::NMI_MASK_RST;
            irq_out_reg   <= 1'b0;
            nmi_out_reg   <= 1'b0;
        end else if (ctl.item_valid && ctl.advance) begin
            irq_latch_reg <= irq_latch_next;
            irq_mask_reg  <= irq_mask_next;
            nmi_latch_reg <= nmi_latch_next;
            nmi_mask_reg  <= nmi_mask_next;
            irq_out_reg   <= irq_out_next;
            nmi_out_reg   <= nmi_out_next;
        end
    end

    // Mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= inlmc_pkg::MODE_EARLY;
        end else if (cfg_valid) begin
            mode_reg <= cfg_data;
        end
    end

endmodule

// ----- rtl/inlmc_out_stage.sv -----
module inlmc_out_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 item_valid,
    input  inlmc_pkg::out_item_t result,
    output logic                 advance,
    output logic                 m_valid,
    input  logic                 m_ready,
    output inlmc_pkg::out_item_t m_data
);

    logic                 valid_reg;
    logic                 valid_next;
    inlmc_pkg::out_item_t data_reg;

    // Move the held item on when the result register is free or draining
    assign advance = item_valid && (!valid_reg || m_ready);

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            data_reg <= result;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// ----- rtl/irq_nmi_latch_mask_controller.sv -----
// A result beat is built from the input register by the event logic and held in
// the result register.
// Throughput: one beat per cycle; the input side stalls only while m_ready is low.
// The configuration channel is always ready and takes effect on the next item.
// Reset (aresetn low, synchronous) empties both registers, sets early mode,
// clears IRQ latch and mask, sets NMI latch to 0x01 and NMI mask to 0x20.
module irq_nmi_latch_mask_controller (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  inlmc_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output inlmc_pkg::out_item_t m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data
);

    inlmc_pkg::pipe_ctl_t ctl;
    inlmc_pkg::in_item_t  item;
    inlmc_pkg::out_item_t result;
    logic                 item_valid;
    logic                 advance;

    assign cfg_ready      = 1'b1;
    assign ctl.item_valid = item_valid;
    assign ctl.advance    = advance;

    inlmc_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    inlmc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .ctl       (ctl),
        .item      (item),
        .result    (result)
    );

    inlmc_out_stage u_out_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .result     (result),
        .advance    (advance),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

// ----- rtl/inlmc_checker.sv -----
`include "irq_nmi_latch_mask_controller_defines.svh"

module inlmc_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input inlmc_pkg::out_item_t m_data
);

    // Hold a stalled result beat
    `INLMC_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_data), "result beat dropped or changed while stalled")

    // Empty the result register on reset
    `INLMC_ASSERT_ALWAYS(a_rst_empty, !aresetn |=> !m_valid, "result valid after reset")

    // Signal NMI-seen clear only with the NMI line low
    `INLMC_ASSERT(a_nmi_clear, m_valid && m_data.nmi_seen_clear |-> !m_data.nmi_line, "NMI-seen clear with NMI line high")

    // Keep the input open whenever the result side drains
    `INLMC_ASSERT(a_no_bubble, m_ready |-> s_ready, "input stalled with result side ready")

endmodule

bind irq_nmi_latch_mask_controller inlmc_checker u_inlmc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ----- test/tb_irq_nmi_latch_mask_controller.sv -----
`timescale 1ns / 100ps

module tb_irq_nmi_latch_mask_controller;

    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int SETTLE       = 4;
    localparam int HOLD_OFF     = 40;
    localparam int MAX_REPORTS  = 10;

    // Spare event codes with no function in the block
    localparam logic [3:0] OP_SPARE_A = 4'd14;
    localparam logic [3:0] OP_SPARE_B = 4'd15;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    inlmc_pkg::in_item_t  s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    inlmc_pkg::out_item_t m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_data = 1'b0;

    // Mirror of the controller state
    logic       mach_mode = inlmc_pkg::MODE_EARLY;
    logic [7:0] irq_lat   = inlmc_pkg::IRQ_LATCH_RST;
    logic [7:0] irq_msk   = inlmc_pkg::IRQ_MASK_RST;
    logic [7:0] nmi_lat   = inlmc_pkg::NMI_LATCH_RST;
    logic [7:0] nmi_msk   = inlmc_pkg::NMI_MASK_RST;
    logic       irq_drv   = 1'b0;
    logic       nmi_drv   = 1'b0;

    inlmc_pkg::out_item_t expected_status[$];
    int                   fail_count = 0;
    bit                   src_gaps_on = 1'b1;
    bit                   sink_stalls_on = 1'b1;
    int                   hold_off_cycles = 0;

    irq_nmi_latch_mask_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    function automatic logic [7:0] with_bit(logic [7:0] v, logic [7:0] m, logic on);
        return on ? (v | m) : (v & ~m);
    endfunction

    // Apply one event to the mirrored state and return the status it reports
    function automatic inlmc_pkg::out_item_t apply_event(inlmc_pkg::in_item_t ev);
        inlmc_pkg::out_item_t res;
        logic                 nmi_hit;
        logic [7:0]           ubit;
        res = '0;
        nmi_hit = 1'b0;
        case (ev.opcode)
            inlmc_pkg::OP_TIMER: begin
                if (mach_mode == inlmc_pkg::MODE_EARLY) begin
                    irq_lat = with_bit(irq_lat, inlmc_pkg::EARLY_TIMER, ev.line_level);
                    if (ev.line_level) irq_drv = 1'b1;
                end else begin
                    irq_lat = with_bit(irq_lat, inlmc_pkg::LATE_TIMER, ev.line_level);
                    irq_drv = |(irq_lat & irq_msk);
                end
            end
            inlmc_pkg::OP_DISK: begin
                if (mach_mode == inlmc_pkg::MODE_EARLY) begin
                    irq_lat = with_bit(irq_lat, inlmc_pkg::EARLY_DISK, ev.line_level);
                    if (ev.line_level) irq_drv = 1'b1;
                end else begin
                    nmi_lat = with_bit(nmi_lat, inlmc_pkg::NMI_INTRQ, ev.line_level);
                    nmi_drv = |(nmi_lat & nmi_msk);
                    nmi_hit = 1'b1;
                end
            end
            inlmc_pkg::OP_MOTOROFF: begin
                if (mach_mode == inlmc_pkg::MODE_LATE) begin
                    nmi_lat = with_bit(nmi_lat, inlmc_pkg::NMI_MOTOROFF, ev.line_level);
                    nmi_drv = |(nmi_lat & nmi_msk);
                    nmi_hit = 1'b1;
                end
            end
            inlmc_pkg::OP_UART_ERR, inlmc_pkg::OP_UART_RCV, inlmc_pkg::OP_UART_SND: begin
                if (mach_mode == inlmc_pkg::MODE_LATE) begin
                    ubit = (ev.opcode == inlmc_pkg::OP_UART_ERR) ? inlmc_pkg::LATE_UART_ERR :
                           (ev.opcode == inlmc_pkg::OP_UART_RCV) ? inlmc_pkg::LATE_UART_RCV :
                                                                   inlmc_pkg::LATE_UART_SND;
                    irq_lat = with_bit(irq_lat, ubit, ev.line_level);
                    irq_drv = |(irq_lat & irq_msk);
                end
            end
            inlmc_pkg::OP_RESET_BTN: begin
                if (mach_mode == inlmc_pkg::MODE_EARLY) begin
                    nmi_drv = ev.line_level;
                end else begin
                    nmi_lat = with_bit(nmi_lat, inlmc_pkg::NMI_RESET, ev.line_level);
                    nmi_drv = |(nmi_lat & nmi_msk);
                end
                nmi_hit = 1'b1;
            end
            inlmc_pkg::OP_CASS_RISE: begin
                irq_lat = (irq_lat & ~inlmc_pkg::CASS_RISE) | (irq_msk & inlmc_pkg::CASS_RISE);
                irq_drv = |(irq_lat & irq_msk);
            end
            inlmc_pkg::OP_CASS_FALL: begin
                irq_lat = (irq_lat & ~inlmc_pkg::CASS_FALL) | (irq_msk & inlmc_pkg::CASS_FALL);
                irq_drv = |(irq_lat & irq_msk);
            end
            inlmc_pkg::OP_CASS_CLEAR: begin
                irq_lat = irq_lat & ~(inlmc_pkg::CASS_RISE | inlmc_pkg::CASS_FALL);
                irq_drv = |(irq_lat & irq_msk);
            end
            inlmc_pkg::OP_IRQ_READ: begin
                if (mach_mode == inlmc_pkg::MODE_EARLY) begin
                    res.read_data = irq_lat;
                    // Acknowledge the timer only
                    irq_lat = irq_lat & ~inlmc_pkg::EARLY_TIMER;
                    irq_drv = |irq_lat;
                end else begin
                    res.read_data = ~irq_lat;
                end
            end
            inlmc_pkg::OP_IRQ_MASK_WR: begin
                irq_msk = ev.write_data;
                irq_drv = |(irq_lat & irq_msk);
            end
            inlmc_pkg::OP_NMI_READ: res.read_data = ~nmi_lat;
            inlmc_pkg::OP_NMI_MASK_WR: begin
                // Reset bit is always unmasked
                nmi_msk = ev.write_data | inlmc_pkg::NMI_RESET;
                nmi_drv = |(nmi_lat & nmi_msk);
                nmi_hit = 1'b1;
            end
            default: ;
        endcase
        res.irq_line         = irq_drv;
        res.nmi_line         = nmi_drv;
        res.nmi_seen_clear   = nmi_hit && !nmi_drv;
        res.cassette_enabled = irq_msk[1:0];
        return res;
    endfunction

    function automatic inlmc_pkg::in_item_t make_event(logic [3:0] op, logic lvl,
                                                        logic [7:0] wd);
        inlmc_pkg::in_item_t ev;
        ev.opcode     = op;
        ev.line_level = lvl;
        ev.write_data = wd;
        return ev;
    endfunction

    function automatic inlmc_pkg::in_item_t random_event();
        inlmc_pkg::in_item_t ev;
        ev.opcode     = 4'($urandom_range(0, 15));
        ev.line_level = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
            0:       ev.write_data = 8'h00;
            1:       ev.write_data = 8'hff;
            default: ev.write_data = 8'($urandom_range(0, 255));
        endcase
        return ev;
    endfunction

    // Offer one beat, hold it until accepted, then record its expected status
    task automatic send_event(input inlmc_pkg::in_item_t ev);
        int gap;
        if (src_gaps_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 12);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= ev;
        do @(posedge aclk); while (!s_ready);
        expected_status.push_back(apply_event(ev));
    endtask

    // Drop valid and wait until every expected status has come back
    task automatic wait_for_results();
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        while (expected_status.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        while (expected_status.size() != 0) begin
            void'(expected_status.pop_front());
            note_failure("expected status never arrived");
        end
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_machine_mode(input logic m);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        mach_mode = m;
    endtask

    task automatic test_reset_values();
        set_machine_mode(inlmc_pkg::MODE_EARLY);
        send_event(make_event(inlmc_pkg::OP_NMI_READ, 1'b0, 8'h00));
        send_event(make_event(inlmc_pkg::OP_IRQ_READ, 1'b1, 8'hff));
        send_event(make_event(OP_SPARE_A, 1'b1, 8'hff));
        send_event(make_event(OP_SPARE_B, 1'b0, 8'h00));
        wait_for_results();
    endtask

    task automatic test_early_events();
        send_event(make_event(inlmc_pkg::OP_TIMER, 1'b1, 8'h00));
        // Disk low clears its bit but leaves the line up
        send_event(make_event(inlmc_pkg::OP_DISK, 1'b0, 8'h00));
        send_event(make_event(inlmc_pkg::OP_IRQ_READ, 1'b0, 8'h00));
        send_event(make_event(inlmc_pkg::OP_MOTOROFF, 1'b1, 8'h00));
        send_event(make_event(inlmc_pkg::OP_UART_RCV, 1'b1, 8'h00));
        send_event(make_event(inlmc_pkg::OP_RESET_BTN, 1'b1, 8'h00));
        send_event(make_event(inlmc_pkg::OP_RESET_BTN, 1'b0, 8'h00));
        send_event(make_event(inlmc_pkg::OP_IRQ_MASK_WR, 1'b0, 8'hff));
        send_event(make_event(inlmc_pkg::OP_CASS_RISE, 1'b0, 8'h00));
        send_event(make_event(inlmc_pkg::OP_CASS_CLEAR, 1'b0, 8'h00));
        send_event(make_event(inlmc_pkg::OP_NMI_MASK_WR, 1'b0, 8'h00));
        wait_for_results();
    endtask

    task automatic test_late_events();
        set_machine_mode(inlmc_pkg::MODE_LATE);
        send_event(make_event(inlmc_pkg::OP_TIMER, 1'b1, 8'h00));
        send_event(make_event(inlmc_pkg::OP_UART_ERR, 1'b1, 8'h00));
        send_event(make_event(inlmc_pkg::OP_UART_SND, 1'b0, 8'h00));
        send_event(make_event(inlmc_pkg::OP_DISK, 1'b1, 8'h00));
        send_event(make_event(inlmc_pkg::OP_MOTOROFF, 1'b1, 8'h00));
        send_event(make_event(inlmc_pkg::OP_RESET_BTN, 1'b0, 8'h00));
        send_event(make_event(inlmc_pkg::OP_NMI_MASK_WR, 1'b0, 8'hff));
        send_event(make_event(inlmc_pkg::OP_CASS_FALL, 1'b0, 8'h00));
        send_event(make_event(inlmc_pkg::OP_IRQ_READ, 1'b0, 8'h00));
        send_event(make_event(inlmc_pkg::OP_NMI_READ, 1'b0, 8'h00));
        send_event(make_event(inlmc_pkg::OP_IRQ_MASK_WR, 1'b1, 8'h00));
        wait_for_results();
    endtask

    // Alternate modes; each phase picks whether either side idles
    task automatic test_random_traffic();
        for (int phase = 0; phase < 4; phase++) begin
            set_machine_mode(phase[0] ? inlmc_pkg::MODE_EARLY : inlmc_pkg::MODE_LATE);
            src_gaps_on    = ($urandom_range(0, 3) != 0);
            sink_stalls_on = ($urandom_range(0, 3) != 0);
            repeat (150) send_event(random_event());
            wait_for_results();
        end
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
    endtask

    // Hold the result side off while beats keep coming so the input stalls
    task automatic test_input_stall();
        src_gaps_on = 1'b0;
        hold_off_cycles = HOLD_OFF;
        repeat (30) send_event(random_event());
        wait_for_results();
    endtask

    task automatic test_steady_stream();
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        set_machine_mode(1'($urandom_range(0, 1)));
        repeat (100) send_event(random_event());
        wait_for_results();
    endtask

    // Result side: random stalls plus an occasional long hold-off
    initial begin : result_sink
        int n;
        forever begin
            @(posedge aclk);
            if (hold_off_cycles != 0) begin
                n = hold_off_cycles;
                hold_off_cycles = 0;
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (sink_stalls_on && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 12);
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Compare each accepted status beat with the oldest expectation
    always @(posedge aclk) begin : status_check
        inlmc_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_status.size() == 0) begin
                note_failure("status beat with no expectation pending");
            end else begin
                want = expected_status.pop_front();
                if (m_data.read_data !== want.read_data ||
                    m_data.irq_line !== want.irq_line ||
                    m_data.nmi_line !== want.nmi_line ||
                    m_data.nmi_seen_clear !== want.nmi_seen_clear ||
                    m_data.cassette_enabled !== want.cassette_enabled) begin
                    note_failure($sformatf(
                        {"status mismatch exp/got: read_data %02h/%02h irq %0b/%0b ",
                         "nmi %0b/%0b seen_clr %0b/%0b cass %0b/%0b"},
                        want.read_data, m_data.read_data, want.irq_line, m_data.irq_line,
                        want.nmi_line, m_data.nmi_line, want.nmi_seen_clear,
                        m_data.nmi_seen_clear, want.cassette_enabled,
                        m_data.cassette_enabled));
                end
            end
        end
    end

    initial begin : watchdog
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_values();
        test_early_events();
        test_late_events();
        test_random_traffic();
        test_input_stall();
        test_steady_stream();
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
